FILE: design/sdbf_pkg.sv
package sdbf_pkg;

  localparam logic [31:0] START_WORD = 32'hFFFF_FFF0;
  localparam logic [31:0] STOP_WORD  = 32'hFFFF_FFFF;

  // CRC16-CCITT taps x^5 and x^12, four interleaved lanes per bit position
  localparam int unsigned TAP5_SHIFT  = 5 * 4;
  localparam int unsigned TAP12_SHIFT = 12 * 4;

  typedef struct packed {
    logic [31:0] data_word;
    logic        last_word;
  } in_t;

  typedef struct packed {
    logic [31:0] bus_word;
    logic        end_of_block;
  } out_t;

  typedef enum logic [4:0] {
    PH_HEAD   = 5'b00001,
    PH_DATA   = 5'b00010,
    PH_CRC_HI = 5'b00100,
    PH_CRC_LO = 5'b01000,
    PH_STOP   = 5'b10000
  } phase_t;

endpackage

FILE: design/sdbf_crc_step.sv
module sdbf_crc_step (
  input  logic [63:0] crc,
  input  logic [31:0] word,
  output logic [63:0] crc_nxt
);

  logic [31:0] fb;
  logic [63:0] fb_ext;

  // eight bit times at once: the 16-bit fold covers the x^16 feedback overlap
  always_comb begin
    fb      = crc[63:32] ^ word;
    fb      = fb ^ (fb >> 16);
    fb_ext  = {32'b0, fb};
    crc_nxt = {crc[31:0], 32'b0} ^ fb_ext
            ^ (fb_ext << sdbf_pkg::TAP5_SHIFT)
            ^ (fb_ext << sdbf_pkg::TAP12_SHIFT);
  end

endmodule

FILE: design/sd_data_block_framer_crc16_4bit.sv
// SD 4-bit data block framer. Each accepted word is eight nibbles, one bit per data line;
// the block emits a start word 0xFFFFFFF0 ahead of the first word of a block, passes every
// data word through, and after the word flagged last emits the interleaved per-line
// CRC16-CCITT as a high and a low word followed by the stop word 0xFFFFFFFF (end_of_block
// set). The single output register emits one word per cycle while out_ready is high; an
// input word is held until any start, CRC and stop words it brings have been loaded, and the next
// input word is taken in the same cycle the current one's final result is loaded.
module sd_data_block_framer_crc16_4bit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  sdbf_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output sdbf_pkg::out_t out_data
);

  logic              hold_vld_r, hold_vld_nxt;
  sdbf_pkg::in_t     hold_r;
  sdbf_pkg::phase_t  phase_r, phase_nxt;
  logic              in_block_r, in_block_nxt;
  logic [63:0]       crc_r, crc_nxt;
  logic [63:0]       crc_adv;
  logic              out_vld_r, out_vld_nxt;
  sdbf_pkg::out_t    out_r, emit;

  logic load, fire, retire, accept;

  sdbf_crc_step u_crc (
    .crc     (crc_r),
    .word    (hold_r.data_word),
    .crc_nxt (crc_adv)
  );

  assign load     = !out_vld_r || out_ready;
  assign fire     = hold_vld_r && load;
  assign in_ready = !hold_vld_r || retire;
  assign accept   = in_valid && in_ready;

  always_comb begin
    emit         = '{bus_word: hold_r.data_word, end_of_block: 1'b0};
    phase_nxt    = phase_r;
    in_block_nxt = in_block_r;
    retire       = 1'b0;
    crc_nxt      = crc_r;
    case (phase_r)
      sdbf_pkg::PH_HEAD, sdbf_pkg::PH_DATA: begin
        if (phase_r == sdbf_pkg::PH_HEAD && !in_block_r) begin
          emit.bus_word = sdbf_pkg::START_WORD;
          if (fire) begin
            in_block_nxt = 1'b1;
            phase_nxt    = sdbf_pkg::PH_DATA;
          end
        end else begin
          if (fire) begin
            crc_nxt = crc_adv;
            if (hold_r.last_word) begin
              phase_nxt = sdbf_pkg::PH_CRC_HI;
            end else begin
              retire = 1'b1;
            end
          end
        end
      end
      sdbf_pkg::PH_CRC_HI: begin
        emit.bus_word = crc_r[63:32];
        if (fire) begin
          phase_nxt = sdbf_pkg::PH_CRC_LO;
        end
      end
      sdbf_pkg::PH_CRC_LO: begin
        emit.bus_word = crc_r[31:0];
        if (fire) begin
          phase_nxt = sdbf_pkg::PH_STOP;
        end
      end
      sdbf_pkg::PH_STOP: begin
        emit = '{bus_word: sdbf_pkg::STOP_WORD, end_of_block: 1'b1};
        if (fire) begin
          retire       = 1'b1;
          crc_nxt      = '0;
          in_block_nxt = 1'b0;
        end
      end
      default: begin
        emit = '{bus_word: hold_r.data_word, end_of_block: 1'b0};
      end
    endcase

    if (accept) begin
      phase_nxt = sdbf_pkg::PH_HEAD;
    end
    hold_vld_nxt = accept ? 1'b1 : (retire ? 1'b0 : hold_vld_r);
    out_vld_nxt  = fire ? 1'b1 : (load ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      phase_r    <= sdbf_pkg::PH_HEAD;
      in_block_r <= 1'b0;
      crc_r      <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      hold_vld_r <= hold_vld_nxt;
      phase_r    <= phase_nxt;
      in_block_r <= in_block_nxt;
      crc_r      <= crc_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= in_data;
    end
    if (fire) begin
      out_r <= emit;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

FILE: design/sdbf_checker.sv
module sdbf_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input sdbf_pkg::out_t out_data
);

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // end of block only ever flags the stop word
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.end_of_block |-> out_data.bus_word == sdbf_pkg::STOP_WORD)
    else $error("end_of_block on a word other than stop");

  // nothing is offered straight out of reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sd_data_block_framer_crc16_4bit sdbf_checker u_sdbf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: sim/tb_sd_data_block_framer_crc16_4bit.sv
module tb_sd_data_block_framer_crc16_4bit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  sdbf_pkg::in_t  in_data;
  logic out_valid;
  logic out_ready;
  sdbf_pkg::out_t out_data;

  // expected bus words, oldest first
  sdbf_pkg::out_t bus_words_due[$];

  // framer model state
  logic [63:0] lane_crc;
  logic        in_block;

  int errors;
  int words_sent;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_request;
  int hold_left;
  int quiet_cycles;

  sd_data_block_framer_crc16_4bit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // four interleaved CRC16-CCITT lanes advanced by eight bit times
  function automatic logic [63:0] lane_crc_next(logic [63:0] crc, logic [31:0] word);
    logic [63:0] fb;
    logic [63:0] nxt;
    fb = {32'd0, crc[63:32] ^ word};
    nxt = crc << 32;
    fb = fb ^ (fb >> 16);
    nxt = nxt ^ fb ^ (fb << sdbf_pkg::TAP5_SHIFT) ^ (fb << sdbf_pkg::TAP12_SHIFT);
    return nxt;
  endfunction

  function automatic sdbf_pkg::out_t bus_word(logic [31:0] w, logic eob);
    sdbf_pkg::out_t r;
    r.bus_word = w;
    r.end_of_block = eob;
    return r;
  endfunction

  task automatic frame_accepted_word(sdbf_pkg::in_t w);
    if (!in_block) begin
      bus_words_due.push_back(bus_word(sdbf_pkg::START_WORD, 1'b0));
      in_block = 1'b1;
    end
    bus_words_due.push_back(bus_word(w.data_word, 1'b0));
    lane_crc = lane_crc_next(lane_crc, w.data_word);
    if (w.last_word) begin
      bus_words_due.push_back(bus_word(lane_crc[63:32], 1'b0));
      bus_words_due.push_back(bus_word(lane_crc[31:0], 1'b0));
      bus_words_due.push_back(bus_word(sdbf_pkg::STOP_WORD, 1'b1));
      lane_crc = '0;
      in_block = 1'b0;
    end
  endtask

  // entered just after a rising edge; leaves valid high after acceptance
  task automatic send_word(logic [31:0] data, logic last);
    sdbf_pkg::in_t w;
    w.data_word = data;
    w.last_word = last;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    frame_accepted_word(w);
    words_sent++;
  endtask

  function automatic logic [31:0] pick_data();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'd1 << $urandom_range(31);
      3: return ~(32'd1 << $urandom_range(31));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_block(int len);
    for (int i = 0; i < len; i++)
      send_word(pick_data(), i == len - 1);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (bus_words_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_word(32'h0000_0000, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b1);
    send_word(sdbf_pkg::START_WORD, 1'b1);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h0000_0001, 1'b1);
    send_word(32'h1234_5678, 1'b0);
    send_word(32'hA5A5_A5A5, 1'b0);
    send_word(32'h5A5A_5A5A, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1);
    // one nibble lit at a time across a block
    for (int k = 0; k < 8; k++)
      send_word(32'hF << (4 * k), k == 7);
    send_word(sdbf_pkg::STOP_WORD, 1'b0);
    send_word(32'h0000_0000, 1'b1);
  endtask

  task automatic test_random(int n);
    int target;
    target = words_sent + n;
    while (words_sent < target)
      send_block(($urandom_range(99) < 10) ? $urandom_range(9, 40) : $urandom_range(1, 8));
  endtask

  // receiver holds off while blocks keep coming, so the framer backs up
  task automatic test_backpressure();
    int saved;
    saved = tx_idle_pct;
    tx_idle_pct = 0;
    hold_request = LONG_HOLD;
    send_block(1);
    send_block(6);
    send_block(1);
    send_block(3);
    wait_drained();
    tx_idle_pct = saved;
  endtask

  // sender stops until everything is out, both mid-block and between blocks
  task automatic test_pause();
    send_word(pick_data(), 1'b0);
    send_word(pick_data(), 1'b0);
    wait_drained();
    send_word(pick_data(), 1'b1);
    wait_drained();
    send_block(2);
  endtask

  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    sdbf_pkg::out_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (bus_words_due.size() == 0) begin
        $display("%0t: unexpected word %h eob %b", $time, out_data.bus_word,
                 out_data.end_of_block);
        errors++;
      end else begin
        exp_w = bus_words_due.pop_front();
        if (out_data.bus_word !== exp_w.bus_word) begin
          $display("%0t: bus_word expected %h got %h", $time, exp_w.bus_word,
                   out_data.bus_word);
          errors++;
        end
        if (out_data.end_of_block !== exp_w.end_of_block) begin
          $display("%0t: end_of_block expected %b got %b", $time, exp_w.end_of_block,
                   out_data.end_of_block);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress, %0d words outstanding", $time, bus_words_due.size());
        $display("tb_sd_data_block_framer_crc16_4bit: FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    errors = 0;
    words_sent = 0;
    hold_request = 0;
    hold_left = 0;
    quiet_cycles = 0;
    lane_crc = '0;
    in_block = 1'b0;
    tx_idle_pct = 24;
    rx_idle_pct = 46;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(100);
    test_backpressure();
    tx_idle_pct = 46;
    rx_idle_pct = 24;
    test_random(100);
    test_pause();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random(100);

    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("tb_sd_data_block_framer_crc16_4bit: PASS");
    else
      $display("tb_sd_data_block_framer_crc16_4bit: FAIL");
    $finish;
  end

endmodule

FILE: files.f
design/sdbf_pkg.sv
design/sdbf_crc_step.sv
design/sd_data_block_framer_crc16_4bit.sv
design/sdbf_checker.sv
sim/tb_sd_data_block_framer_crc16_4bit.sv
